// File: hw/rtl/tepq_pkg.sv
package tepq_pkg;

	localparam int DEPTH      = 16;
	localparam int TIME_BITS  = 64;
	localparam int PHASE_BITS = 2;
	localparam int DELTA_BITS = 16;
	localparam int ID_BITS    = 32;
	localparam int LIVE_BITS  = $clog2(DEPTH + 1);
	localparam int ORDER_BITS = 32;

	typedef enum logic [1:0] {
		ACT_SCHED_ABS = 2'd0,
		ACT_SCHED_REL = 2'd1,
		ACT_CANCEL    = 2'd2,
		ACT_STEP      = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_SCHEDULED  = 4'd0,
		ST_CANCELLED  = 4'd1,
		ST_MISS       = 4'd2,
		ST_DISPATCHED = 4'd3,
		ST_ADVANCED   = 4'd4,
		ST_PAST       = 4'd5,
		ST_BEFORE     = 4'd6,
		ST_OVERFLOW   = 4'd7,
		ST_EARLY      = 4'd8,
		ST_FULL       = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_CANCEL = 2'd2,
		CELL_POP    = 2'd3
	} cell_op_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic     en;
		cell_op_t op;
	} cell_ctl_t;

endpackage

// File: hw/rtl/tepq_cmd_if.sv
interface tepq_cmd_if;
	import tepq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [TIME_BITS-1:0]  time_value;
	logic [PHASE_BITS-1:0] event_phase;
	logic [DELTA_BITS-1:0] event_delta;
	logic [ID_BITS-1:0]    target_id;

	modport source (output valid, action, time_value, event_phase, event_delta, target_id,
		input ready);
	modport sink (input valid, action, time_value, event_phase, event_delta, target_id,
		output ready);
endinterface

// File: hw/rtl/tepq_res_if.sv
interface tepq_res_if;
	import tepq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [3:0]            status;
	logic [ID_BITS-1:0]    out_event_id;
	logic [TIME_BITS-1:0]  out_tick;
	logic [PHASE_BITS-1:0] out_phase;
	logic [DELTA_BITS-1:0] out_delta;
	logic [TIME_BITS-1:0]  now_time;
	logic [LIVE_BITS-1:0]  live_events;

	modport source (output valid, status, out_event_id, out_tick, out_phase, out_delta,
		now_time, live_events, input ready);
	modport sink (input valid, status, out_event_id, out_tick, out_phase, out_delta,
		now_time, live_events, output ready);
endinterface

// File: hw/rtl/tepq_cell.sv
module tepq_cell #(
	parameter int TIME_BITS  = 64,
	parameter int PHASE_BITS = 2,
	parameter int DELTA_BITS = 16,
	parameter int ID_BITS    = 32,
	parameter int ORD_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tepq_pkg::cell_ctl_t   ctl,
	input  logic [TIME_BITS-1:0]  new_tick,
	input  logic [PHASE_BITS-1:0] new_phase,
	input  logic [DELTA_BITS-1:0] new_delta,
	input  logic [ORD_BITS-1:0]   new_order,
	input  logic [ID_BITS-1:0]    new_id,
	input  logic [ID_BITS-1:0]    tid,
	input  logic                  l_valid,
	input  logic [TIME_BITS-1:0]  l_tick,
	input  logic [PHASE_BITS-1:0] l_phase,
	input  logic [DELTA_BITS-1:0] l_delta,
	input  logic [ORD_BITS-1:0]   l_order,
	input  logic [ID_BITS-1:0]    l_id,
	input  logic                  r_valid,
	input  logic [TIME_BITS-1:0]  r_tick,
	input  logic [PHASE_BITS-1:0] r_phase,
	input  logic [DELTA_BITS-1:0] r_delta,
	input  logic [ORD_BITS-1:0]   r_order,
	input  logic [ID_BITS-1:0]    r_id,
	input  logic                  g_in,
	input  logic                  found_in,
	output logic                  valid,
	output logic [TIME_BITS-1:0]  tick,
	output logic [PHASE_BITS-1:0] phase,
	output logic [DELTA_BITS-1:0] delta,
	output logic [ORD_BITS-1:0]   order,
	output logic [ID_BITS-1:0]    id,
	output logic                  g_out,
	output logic                  found_out
);
	import tepq_pkg::*;

	logic                  valid_q;
	logic [TIME_BITS-1:0]  tick_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [DELTA_BITS-1:0] delta_q;
	logic [ORD_BITS-1:0]   order_q;
	logic [ID_BITS-1:0]    id_q;
	logic                  take_new, take_l, take_r;

	// new stamp belongs at or before this cell
	assign g_out = !valid_q ||
		({new_tick, new_phase, new_delta, new_order} < {tick_q, phase_q, delta_q, order_q});
	// first matching id wins, everything from it onwards moves left
	assign found_out = found_in || (valid_q && id_q == tid);

	always_comb begin
		take_new = 1'b0;
		take_l   = 1'b0;
		take_r   = 1'b0;
		if (ctl.en) begin
			unique case (ctl.op)
				CELL_INSERT: begin
					take_l   = g_out && g_in;
					take_new = g_out && !g_in;
				end
				CELL_CANCEL: take_r = found_out;
				CELL_POP:    take_r = 1'b1;
				default:     ;
			endcase
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_l) begin
			valid_q <= l_valid;
		end else if (take_r) begin
			valid_q <= r_valid;
		end
	end

	// event payload
	always_ff @(posedge clk) begin
		if (take_new) begin
			tick_q  <= new_tick;
			phase_q <= new_phase;
			delta_q <= new_delta;
			order_q <= new_order;
			id_q    <= new_id;
		end else if (take_l) begin
			tick_q  <= l_tick;
			phase_q <= l_phase;
			delta_q <= l_delta;
			order_q <= l_order;
			id_q    <= l_id;
		end else if (take_r) begin
			tick_q  <= r_tick;
			phase_q <= r_phase;
			delta_q <= r_delta;
			order_q <= r_order;
			id_q    <= r_id;
		end
	end

	assign valid = valid_q;
	assign tick  = tick_q;
	assign phase = phase_q;
	assign delta = delta_q;
	assign order = order_q;
	assign id    = id_q;
endmodule

// File: hw/rtl/timed_event_priority_queue.sv
// Timed event priority queue.
// Commands arrive on the cmd channel (schedule absolute, schedule after delay,
// cancel by id, step until limit); each command beat yields exactly one result
// beat on the res channel with a status, event fields, current time and the
// number of pending events.
// Pending events sit in a chain of DEPTH cells kept sorted by stamp
// (tick, phase, delta, arrival order), so the earliest event is always in the
// first cell. An insert, a cancel or a dispatch shifts the chain by one place,
// with all cells updated together.
// A command beat is registered on acceptance and executed once the output
// register is free, its result then being registered in the output register.
// A new command beat is not taken until the held one has been executed, set by
// the capture and execute steps around the cell chain update.
// cmd.ready is low while a command is held; a result waiting on a stalled
// receiver does not block the next command beat, which is then executed once
// the output register frees.
// Reset empties the chain and clears time, last stamp and counters at once.
module timed_event_priority_queue (
	input logic clk,
	input logic arst_n,
	tepq_cmd_if.sink   cmd,
	tepq_res_if.source res
);
	import tepq_pkg::*;

	localparam int LW = LIVE_BITS;
	localparam int OB = ORDER_BITS;

	// held command
	logic                  busy_q;
	action_t               act_q;
	logic [TIME_BITS-1:0]  tv_q;
	logic [PHASE_BITS-1:0] ph_q;
	logic [DELTA_BITS-1:0] dl_q;
	logic [ID_BITS-1:0]    tid_q;

	// scheduler state
	logic [TIME_BITS-1:0]  now_q;
	logic                  last_v_q;
	logic [TIME_BITS-1:0]  last_tick_q;
	logic [PHASE_BITS-1:0] last_ph_q;
	logic [DELTA_BITS-1:0] last_dl_q;
	logic [OB-1:0]         last_ord_q;
	logic [OB-1:0]         order_q;
	logic [ID_BITS-1:0]    id_q;
	logic [LW-1:0]         live_q;

	// result register
	logic                  rv_q;
	status_t               rst_q;
	logic [ID_BITS-1:0]    rid_q;
	logic [TIME_BITS-1:0]  rtick_q;
	logic [PHASE_BITS-1:0] rph_q;
	logic [DELTA_BITS-1:0] rdl_q;

	// chain wiring, one extra empty place past the tail
	logic                  c_valid [DEPTH+1];
	logic [TIME_BITS-1:0]  c_tick  [DEPTH+1];
	logic [PHASE_BITS-1:0] c_phase [DEPTH+1];
	logic [DELTA_BITS-1:0] c_delta [DEPTH+1];
	logic [OB-1:0]         c_order [DEPTH+1];
	logic [ID_BITS-1:0]    c_id    [DEPTH+1];
	logic [DEPTH:0]        g_chain;
	logic [DEPTH:0]        f_chain;
	logic [DEPTH-1:0]      valid_vec;

	logic                  exec;
	cell_ctl_t             ctl;
	logic [TIME_BITS:0]    rel_sum;
	logic [TIME_BITS-1:0]  new_tick;
	logic                  is_sched, ovf, past, behind_last, full, early, due;
	status_t               st_d;

	assign cmd.ready = !busy_q;
	assign exec      = busy_q && (!rv_q || res.ready);

	// command capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			act_q <= action_t'(cmd.action);
			tv_q  <= cmd.time_value;
			ph_q  <= cmd.event_phase;
			dl_q  <= cmd.event_delta;
			tid_q <= cmd.target_id;
		end
	end

	// schedule and step checks
	assign is_sched    = (act_q == ACT_SCHED_ABS) || (act_q == ACT_SCHED_REL);
	assign rel_sum     = {1'b0, now_q} + {1'b0, tv_q};
	assign new_tick    = (act_q == ACT_SCHED_REL) ? rel_sum[TIME_BITS-1:0] : tv_q;
	assign ovf         = (act_q == ACT_SCHED_REL) && rel_sum[TIME_BITS];
	assign past        = new_tick < now_q;
	assign behind_last = last_v_q && new_tick == now_q && last_tick_q == now_q &&
		({new_tick, ph_q, dl_q, order_q} < {last_tick_q, last_ph_q, last_dl_q, last_ord_q});
	assign full        = live_q == LW'(DEPTH);
	assign early       = tv_q < now_q;
	assign due         = c_valid[0] && c_tick[0] <= tv_q;

	always_comb begin
		st_d   = ST_ADVANCED;
		ctl.en = exec;
		ctl.op = CELL_HOLD;
		unique case (act_q)
			ACT_SCHED_ABS, ACT_SCHED_REL: begin
				priority if (ovf)      st_d = ST_OVERFLOW;
				else if (past)         st_d = ST_PAST;
				else if (behind_last)  st_d = ST_BEFORE;
				else if (full)         st_d = ST_FULL;
				else begin
					st_d   = ST_SCHEDULED;
					ctl.op = CELL_INSERT;
				end
			end
			ACT_CANCEL: begin
				ctl.op = CELL_CANCEL;
				st_d   = f_chain[DEPTH] ? ST_CANCELLED : ST_MISS;
			end
			default: begin
				priority if (early) st_d = ST_EARLY;
				else if (due) begin
					st_d   = ST_DISPATCHED;
					ctl.op = CELL_POP;
				end else st_d = ST_ADVANCED;
			end
		endcase
	end

	// cell chain
	assign c_valid[DEPTH] = 1'b0;
	assign c_tick[DEPTH]  = '0;
	assign c_phase[DEPTH] = '0;
	assign c_delta[DEPTH] = '0;
	assign c_order[DEPTH] = '0;
	assign c_id[DEPTH]    = '0;
	assign g_chain[0]     = 1'b0;
	assign f_chain[0]     = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  lv;
		logic [TIME_BITS-1:0]  lt;
		logic [PHASE_BITS-1:0] lp;
		logic [DELTA_BITS-1:0] ld;
		logic [OB-1:0]         lo;
		logic [ID_BITS-1:0]    li;
		if (i == 0) begin : g_head
			assign lv = 1'b0;
			assign lt = '0;
			assign lp = '0;
			assign ld = '0;
			assign lo = '0;
			assign li = '0;
		end else begin : g_body
			assign lv = c_valid[i-1];
			assign lt = c_tick[i-1];
			assign lp = c_phase[i-1];
			assign ld = c_delta[i-1];
			assign lo = c_order[i-1];
			assign li = c_id[i-1];
		end
		tepq_cell #(
			.TIME_BITS(TIME_BITS), .PHASE_BITS(PHASE_BITS), .DELTA_BITS(DELTA_BITS),
			.ID_BITS(ID_BITS), .ORD_BITS(OB)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.new_tick(new_tick), .new_phase(ph_q), .new_delta(dl_q),
			.new_order(order_q), .new_id(id_q), .tid(tid_q),
			.l_valid(lv), .l_tick(lt), .l_phase(lp), .l_delta(ld), .l_order(lo), .l_id(li),
			.r_valid(c_valid[i+1]), .r_tick(c_tick[i+1]), .r_phase(c_phase[i+1]),
			.r_delta(c_delta[i+1]), .r_order(c_order[i+1]), .r_id(c_id[i+1]),
			.g_in(g_chain[i]), .found_in(f_chain[i]),
			.valid(c_valid[i]), .tick(c_tick[i]), .phase(c_phase[i]),
			.delta(c_delta[i]), .order(c_order[i]), .id(c_id[i]),
			.g_out(g_chain[i+1]), .found_out(f_chain[i+1])
		);
		assign valid_vec[i] = c_valid[i];
	end

	// time, last stamp and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			last_v_q    <= 1'b0;
			last_tick_q <= '0;
			last_ph_q   <= '0;
			last_dl_q   <= '0;
			last_ord_q  <= '0;
			order_q     <= '0;
			id_q        <= '0;
			live_q      <= '0;
		end else if (exec) begin
			unique case (st_d)
				ST_SCHEDULED: begin
					order_q <= order_q + 1'b1;
					id_q    <= id_q + 1'b1;
					live_q  <= live_q + 1'b1;
				end
				ST_CANCELLED: live_q <= live_q - 1'b1;
				ST_DISPATCHED: begin
					live_q      <= live_q - 1'b1;
					now_q       <= c_tick[0];
					last_v_q    <= 1'b1;
					last_tick_q <= c_tick[0];
					last_ph_q   <= c_phase[0];
					last_dl_q   <= c_delta[0];
					last_ord_q  <= c_order[0];
				end
				ST_ADVANCED: begin
					if (tv_q > now_q) begin
						now_q    <= tv_q;
						last_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (exec) begin
			rv_q <= 1'b1;
		end else if (res.ready) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rst_q   <= st_d;
			rid_q   <= '0;
			rtick_q <= '0;
			rph_q   <= '0;
			rdl_q   <= '0;
			if (st_d == ST_SCHEDULED) begin
				rid_q   <= id_q;
				rtick_q <= new_tick;
				rph_q   <= ph_q;
				rdl_q   <= dl_q;
			end else if (st_d == ST_DISPATCHED) begin
				rid_q   <= c_id[0];
				rtick_q <= c_tick[0];
				rph_q   <= c_phase[0];
				rdl_q   <= c_delta[0];
			end
		end
	end

	assign res.valid        = rv_q;
	assign res.status       = rst_q;
	assign res.out_event_id = rid_q;
	assign res.out_tick     = rtick_q;
	assign res.out_phase    = rph_q;
	assign res.out_delta    = rdl_q;
	assign res.now_time     = now_q;
	assign res.live_events  = live_q;

	// checks
	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		live_q == LW'($countones(valid_vec)))
		else $error("live count disagrees with occupied cells");
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + 1'b1))
		else $error("occupied cells not packed at the head");
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> busy_q && !cmd.ready)
		else $error("command beat not held");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> rv_q && !busy_q)
		else $error("executed command left no result");
endmodule
